@@ design/bid_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bid_pkg: shared types and codes for the bounded indexed deque
// Request and response item layouts, operation and status codes, and the
// command and status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package bid_pkg;

	localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
	localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
	localparam logic [3:0] OP_POP_FRONT  = 4'd2;
	localparam logic [3:0] OP_POP_BACK   = 4'd3;
	localparam logic [3:0] OP_INSERT     = 4'd4;
	localparam logic [3:0] OP_REMOVE     = 4'd5;
	localparam logic [3:0] OP_READ       = 4'd6;
	localparam logic [3:0] OP_REVERSE    = 4'd7;
	localparam logic [3:0] OP_CLEAR      = 4'd8;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [3:0]         op;
		logic signed [31:0] data_value;
		logic [4:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [1:0]         status;
		logic [4:0]         entry_count;
		logic               is_empty;
		logic signed [31:0] front_word;
		logic signed [31:0] back_word;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_WRITE,
		S_POP,
		S_READ,
		S_SHIFT,
		S_FRONT,
		S_BACK,
		S_FIN
	} state_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_GROW_FRONT,
		PTR_GROW_BACK,
		PTR_SHRINK_FRONT,
		PTR_SHRINK_BACK,
		PTR_TOGGLE,
		PTR_CLEAR
	} ptr_op_t;

	typedef enum logic [1:0] {
		SEL_FIRST,
		SEL_LAST,
		SEL_REQ
	} pos_sel_t;

	typedef struct packed {
		logic       load_req;
		ptr_op_t    ptr_op;
		logic       rd_en;
		pos_sel_t   rd_sel;
		logic       wr_en;
		pos_sel_t   wr_sel;
		logic       start_ins;
		logic       start_rem;
		logic       shift_step;
		logic       set_status;
		logic [1:0] status;
		logic       cap_value;
		logic       cap_front;
		logic       load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic [3:0] op;
		logic       full;
		logic       empty;
		logic       pos_over;
		logic       pos_at_or_over;
		logic       shift_done;
	} dp_stat_t;

endpackage

@@ design/bid_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bid_datapath: word store, ring pointers and response register
// Holds the circular word memory with one write and one registered read
// port, the count / first-slot / direction registers, the shift cursor used
// by positional insert and remove, and the registered response item.
// ---------------------------------------------------------------------------
module bid_datapath #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bid_pkg::req_t     req,
	input  bid_pkg::dp_cmd_t  cmd,
	output bid_pkg::dp_stat_t stat,
	output bid_pkg::rsp_t     rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int XW = (CW > 5) ? CW : 5;

	// request latch
	logic [3:0]           req_op_q;
	logic [WORD_BITS-1:0] req_data_q;
	logic [4:0]           req_pos_q;

	// sequence state
	logic [CW-1:0] count_q;
	logic [AW-1:0] first_q;
	logic          rev_q;

	// shift cursor
	logic [CW-1:0] cur_q;
	logic [CW-1:0] wr_pos_q;
	logic [CW-1:0] rem_q;
	logic          up_q;
	logic          pend_q;

	logic [WORD_BITS-1:0] mem_q [DEPTH];
	logic [WORD_BITS-1:0] rd_q;
	logic [WORD_BITS-1:0] value_q;
	logic [WORD_BITS-1:0] front_q;
	logic [1:0]           status_q;
	bid_pkg::rsp_t        rsp_q;

	logic [XW-1:0]        pos_x;
	logic [XW-1:0]        cnt_x;
	logic [CW-1:0]        pos_c;
	logic [CW-1:0]        last_c;
	logic [AW-1:0]        first_dn;
	logic [AW-1:0]        first_up;
	logic [CW-1:0]        rd_pos;
	logic [CW-1:0]        wr_pos;
	logic [AW-1:0]        rd_slot;
	logic [AW-1:0]        wr_slot;
	logic                 rd_go;
	logic                 wr_go;
	logic [WORD_BITS-1:0] wr_word;
	logic                 is_empty;

	function automatic logic [AW-1:0] slot_of(
		input logic [CW-1:0] p,
		input logic [CW-1:0] cnt,
		input logic [AW-1:0] first,
		input logic          rev
	);
		logic [CW-1:0] off;
		logic [AW:0]   sum;
		off = rev ? (cnt - p - CW'(1)) : p;
		sum = {1'b0, first} + (AW+1)'(off);
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [31:0] to32(input logic [WORD_BITS-1:0] w);
		logic [63:0] ext;
		ext = 64'(w);
		return ext[31:0];
	endfunction

	function automatic logic [WORD_BITS-1:0] from32(input logic [31:0] d);
		logic [63:0] ext;
		ext = {32'h0, d};
		return ext[WORD_BITS-1:0];
	endfunction

	function automatic logic [4:0] count5(input logic [CW-1:0] c);
		logic [63:0] ext;
		ext = 64'(c);
		return ext[4:0];
	endfunction

	assign pos_x    = XW'(req_pos_q);
	assign cnt_x    = XW'(count_q);
	assign pos_c    = pos_x[CW-1:0];
	assign last_c   = count_q - CW'(1);
	assign is_empty = (count_q == '0);
	assign first_dn = (first_q == '0) ? AW'(DEPTH - 1) : first_q - AW'(1);
	assign first_up = (first_q == AW'(DEPTH - 1)) ? '0 : first_q + AW'(1);

	assign stat.op             = req_op_q;
	assign stat.full           = (count_q >= CW'(DEPTH));
	assign stat.empty          = is_empty;
	assign stat.pos_over       = (pos_x > cnt_x);
	assign stat.pos_at_or_over = (pos_x >= cnt_x);
	assign stat.shift_done     = (rem_q == '0);

	always_comb begin
		unique case (cmd.rd_sel)
			bid_pkg::SEL_FIRST: rd_pos = '0;
			bid_pkg::SEL_LAST:  rd_pos = last_c;
			bid_pkg::SEL_REQ:   rd_pos = pos_c;
			default:            rd_pos = '0;
		endcase
		unique case (cmd.wr_sel)
			bid_pkg::SEL_FIRST: wr_pos = '0;
			bid_pkg::SEL_LAST:  wr_pos = last_c;
			bid_pkg::SEL_REQ:   wr_pos = pos_c;
			default:            wr_pos = '0;
		endcase
		wr_word = req_data_q;
		if (cmd.shift_step) begin
			rd_pos  = cur_q;
			wr_pos  = wr_pos_q;
			wr_word = rd_q;
		end
		rd_go = cmd.rd_en || (cmd.shift_step && (rem_q != '0));
		wr_go = cmd.wr_en || (cmd.shift_step && pend_q);
	end

	assign rd_slot = slot_of(rd_pos, count_q, first_q, rev_q);
	assign wr_slot = slot_of(wr_pos, count_q, first_q, rev_q);

	always_ff @(posedge clk) begin
		if (wr_go) begin
			mem_q[wr_slot] <= wr_word;
		end
		if (rd_go) begin
			rd_q <= mem_q[rd_slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			first_q <= '0;
			rev_q   <= 1'b0;
		end else begin
			unique case (cmd.ptr_op)
				bid_pkg::PTR_HOLD: ;
				bid_pkg::PTR_GROW_FRONT: begin
					if (!rev_q) first_q <= first_dn;
					count_q <= count_q + CW'(1);
				end
				bid_pkg::PTR_GROW_BACK: begin
					if (rev_q) first_q <= first_dn;
					count_q <= count_q + CW'(1);
				end
				bid_pkg::PTR_SHRINK_FRONT: begin
					if (!rev_q) first_q <= first_up;
					count_q <= count_q - CW'(1);
				end
				bid_pkg::PTR_SHRINK_BACK: begin
					if (rev_q) first_q <= first_up;
					count_q <= count_q - CW'(1);
				end
				bid_pkg::PTR_TOGGLE: begin
					rev_q <= ~rev_q;
				end
				bid_pkg::PTR_CLEAR: begin
					count_q <= '0;
					first_q <= '0;
					rev_q   <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// cursor walks away from the gap: down for insert, up for remove
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			pend_q   <= 1'b0;
			up_q     <= 1'b0;
			cur_q    <= '0;
			wr_pos_q <= '0;
		end else if (cmd.start_ins) begin
			rem_q  <= CW'(cnt_x - pos_x);
			cur_q  <= last_c;
			up_q   <= 1'b0;
			pend_q <= 1'b0;
		end else if (cmd.start_rem) begin
			rem_q  <= CW'(cnt_x - pos_x - XW'(1));
			cur_q  <= CW'(pos_x + XW'(1));
			up_q   <= 1'b1;
			pend_q <= 1'b0;
		end else if (cmd.shift_step) begin
			if (rem_q != '0) begin
				cur_q    <= up_q ? cur_q + CW'(1) : cur_q - CW'(1);
				wr_pos_q <= up_q ? cur_q - CW'(1) : cur_q + CW'(1);
				rem_q    <= rem_q - CW'(1);
				pend_q   <= 1'b1;
			end else begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_op_q   <= req.op;
			req_data_q <= from32(req.data_value);
			req_pos_q  <= req.position;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
			value_q  <= '0;
		end
		if (cmd.cap_value) begin
			value_q <= rd_q;
		end
		if (cmd.cap_front) begin
			front_q <= rd_q;
		end
		if (cmd.load_out) begin
			rsp_q.result_value <= to32(value_q);
			rsp_q.status       <= status_q;
			rsp_q.entry_count  <= count5(count_q);
			rsp_q.is_empty     <= is_empty;
			rsp_q.front_word   <= is_empty ? 32'sd0 : to32(front_q);
			rsp_q.back_word    <= is_empty ? 32'sd0 : to32(rd_q);
		end
	end

	assign rsp = rsp_q;

`ifndef SYNTHESIS
	a_grow_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ptr_op == bid_pkg::PTR_GROW_FRONT || cmd.ptr_op == bid_pkg::PTR_GROW_BACK)
		|=> count_q == $past(count_q) + CW'(1))
		else $error("count did not advance on grow");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift_step && pend_q) |-> !cmd.wr_en)
		else $error("shift commit collides with data write");
`endif

endmodule

@@ design/bid_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bid_ctrl: request sequencer for the bounded indexed deque
// Decodes each item, steps the datapath through write, pop, read or shift,
// fetches the front and back words and hands the item to the response
// register when the output side can take it.
// ---------------------------------------------------------------------------
module bid_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  bid_pkg::dp_stat_t stat,
	output bid_pkg::dp_cmd_t  cmd
);

	bid_pkg::state_t state_q;
	bid_pkg::state_t state_d;
	logic            rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bid_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.load_req = req_valid && (state_q == bid_pkg::S_IDLE);
		unique case (state_q)
			bid_pkg::S_IDLE: begin
				if (req_valid) state_d = bid_pkg::S_DECODE;
			end
			bid_pkg::S_DECODE: begin
				cmd.set_status = 1'b1;
				cmd.status     = bid_pkg::ST_OK;
				state_d        = bid_pkg::S_FRONT;
				unique case (stat.op) inside
					bid_pkg::OP_PUSH_FRONT, bid_pkg::OP_PUSH_BACK: begin
						if (stat.full) begin
							cmd.status = bid_pkg::ST_FULL;
						end else begin
							cmd.ptr_op = (stat.op == bid_pkg::OP_PUSH_FRONT) ?
								bid_pkg::PTR_GROW_FRONT : bid_pkg::PTR_GROW_BACK;
							state_d = bid_pkg::S_WRITE;
						end
					end
					bid_pkg::OP_POP_FRONT, bid_pkg::OP_POP_BACK: begin
						if (stat.empty) begin
							cmd.status = bid_pkg::ST_EMPTY;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = (stat.op == bid_pkg::OP_POP_FRONT) ?
								bid_pkg::SEL_FIRST : bid_pkg::SEL_LAST;
							state_d = bid_pkg::S_POP;
						end
					end
					bid_pkg::OP_INSERT: begin
						if (stat.pos_over) begin
							cmd.status = bid_pkg::ST_RANGE;
						end else if (stat.full) begin
							cmd.status = bid_pkg::ST_FULL;
						end else begin
							cmd.ptr_op    = bid_pkg::PTR_GROW_BACK;
							cmd.start_ins = 1'b1;
							state_d       = bid_pkg::S_SHIFT;
						end
					end
					bid_pkg::OP_REMOVE: begin
						if (stat.pos_at_or_over) begin
							cmd.status = bid_pkg::ST_RANGE;
						end else begin
							cmd.start_rem = 1'b1;
							state_d       = bid_pkg::S_SHIFT;
						end
					end
					bid_pkg::OP_READ: begin
						if (stat.pos_at_or_over) begin
							cmd.status = bid_pkg::ST_RANGE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = bid_pkg::SEL_REQ;
							state_d    = bid_pkg::S_READ;
						end
					end
					bid_pkg::OP_REVERSE: cmd.ptr_op = bid_pkg::PTR_TOGGLE;
					bid_pkg::OP_CLEAR:   cmd.ptr_op = bid_pkg::PTR_CLEAR;
					default: ;
				endcase
			end
			bid_pkg::S_WRITE: begin
				cmd.wr_en = 1'b1;
				if (stat.op == bid_pkg::OP_PUSH_FRONT) begin
					cmd.wr_sel = bid_pkg::SEL_FIRST;
				end else if (stat.op == bid_pkg::OP_PUSH_BACK) begin
					cmd.wr_sel = bid_pkg::SEL_LAST;
				end else begin
					cmd.wr_sel = bid_pkg::SEL_REQ;
				end
				state_d = bid_pkg::S_FRONT;
			end
			bid_pkg::S_POP: begin
				cmd.cap_value = 1'b1;
				cmd.ptr_op    = (stat.op == bid_pkg::OP_POP_FRONT) ?
					bid_pkg::PTR_SHRINK_FRONT : bid_pkg::PTR_SHRINK_BACK;
				state_d = bid_pkg::S_FRONT;
			end
			bid_pkg::S_READ: begin
				cmd.cap_value = 1'b1;
				state_d       = bid_pkg::S_FRONT;
			end
			bid_pkg::S_SHIFT: begin
				// one word moves per cycle; the last pending write lands here too
				cmd.shift_step = 1'b1;
				if (stat.shift_done) begin
					if (stat.op == bid_pkg::OP_REMOVE) begin
						cmd.ptr_op = bid_pkg::PTR_SHRINK_BACK;
						state_d    = bid_pkg::S_FRONT;
					end else begin
						state_d = bid_pkg::S_WRITE;
					end
				end
			end
			bid_pkg::S_FRONT: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = bid_pkg::SEL_FIRST;
				state_d    = bid_pkg::S_BACK;
			end
			bid_pkg::S_BACK: begin
				cmd.cap_front = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = bid_pkg::SEL_LAST;
				state_d       = bid_pkg::S_FIN;
			end
			bid_pkg::S_FIN: begin
				// hold the back word in the read register until the output frees
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = bid_pkg::S_IDLE;
				end
			end
			default: state_d = bid_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign req_ready = (state_q == bid_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;

`ifndef SYNTHESIS
	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> state_q == bid_pkg::S_DECODE)
		else $error("accepted item not decoded");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp_valid_q || rsp_ready))
		else $error("response register overwritten");
	a_shift_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bid_pkg::S_SHIFT && stat.shift_done)
		|=> (state_q == bid_pkg::S_WRITE || state_q == bid_pkg::S_FRONT))
		else $error("shift did not finish");
`endif

endmodule

@@ design/bounded_indexed_deque_core.sv @@
`timescale 1ns / 1ps
// Sequence: each item is decoded; a push writes its word, a pop or read fetches one word;
// insert moves the words from its position on back, one word per cycle, then writes its word;
// remove moves the words behind it forward; then front and back are read for the response.
// Throughput: one item at a time; the next item is accepted the cycle after the
// response register loads, even while that response still waits to be taken.
// Reset: arst_n clears count, first slot, direction and handshake state; no sweep.
// ---------------------------------------------------------------------------
// bounded_indexed_deque_core: bounded deque with positional insert/remove
// Ties the request sequencer to the word-store datapath.
// ---------------------------------------------------------------------------
module bounded_indexed_deque_core #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bid_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bid_pkg::rsp_t rsp
);

	bid_pkg::dp_cmd_t  cmd;
	bid_pkg::dp_stat_t stat;

	bid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bid_datapath #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the bounded indexed deque core
// Drives a short table of requests that covers empty, full and out-of-range
// cases and every operation, then weighted random traffic that grows and
// drains the store. A local shadow deque predicts each unpinned response;
// all are compared field by field in order. Both handshakes stall at random.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int DEPTH        = 16;
	localparam int WORD_BITS    = 32;
	localparam int BURSTS       = 17;
	localparam int BURST_ITEMS  = 100;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = DEPTH + 12;
	localparam int HOLD_CYCLES  = 400;
	localparam int REPORT_MAX   = 10;

	localparam logic [3:0]  OP_SPARE_FIRST = 4'd9;
	localparam logic [3:0]  OP_SPARE_LAST  = 4'd15;
	localparam logic [31:0] WORD_MIN       = 32'h8000_0000;
	localparam logic [31:0] WORD_MAX       = 32'h7FFF_FFFF;
	localparam logic [31:0] WORD_ONES      = 32'hFFFF_FFFF;
	localparam logic [4:0]  POS_TOP        = 5'd31;

	typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

	typedef struct {
		bid_pkg::req_t rq;
		int            reps;
		bit            pinned;
		bid_pkg::rsp_t want;
	} step_t;

	logic          clk;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	bid_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	bid_pkg::rsp_t rsp;

	// shadow of the deque
	logic [WORD_BITS-1:0] shadow_words [DEPTH];
	int unsigned          held    = 0;
	logic [3:0]           head    = '0;
	bit                   flipped = 1'b0;

	bid_pkg::rsp_t pending_rsp [$];
	bit            calm       = 1'b0;
	bit            hold_now   = 1'b0;
	int unsigned   cycles     = 0;
	int unsigned   sent       = 0;
	int unsigned   taken      = 0;
	int unsigned   mismatches = 0;
	int unsigned   holds_done = 0;
	int unsigned   status_seen [4] = '{0, 0, 0, 0};

	bounded_indexed_deque_core #(
		.DEPTH    (DEPTH),
		.WORD_BITS(WORD_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int unsigned slot_at(int unsigned p);
		int unsigned off;
		off = flipped ? held - 1 - p : p;
		return (head + off % DEPTH) % DEPTH;
	endfunction

	// the head slot moves only when the logical end maps to the low side
	function automatic void extend(bit at_front);
		if (at_front != flipped)
			head = head - 4'd1;
		held++;
	endfunction

	function automatic void shrink(bit at_front);
		if (at_front != flipped)
			head = head + 4'd1;
		held--;
	endfunction

	function automatic bid_pkg::rsp_t deque_apply(bid_pkg::req_t r);
		bid_pkg::rsp_t o;
		int unsigned   pos;
		int unsigned   i;
		o   = '0;
		pos = r.position;
		case (r.op) inside
			bid_pkg::OP_PUSH_FRONT, bid_pkg::OP_PUSH_BACK: begin
				if (held >= DEPTH) begin
					o.status = bid_pkg::ST_FULL;
				end else if (r.op == bid_pkg::OP_PUSH_FRONT) begin
					extend(1'b1);
					shadow_words[slot_at(0)] = r.data_value;
				end else begin
					extend(1'b0);
					shadow_words[slot_at(held - 1)] = r.data_value;
				end
			end
			bid_pkg::OP_POP_FRONT, bid_pkg::OP_POP_BACK: begin
				if (held == 0) begin
					o.status = bid_pkg::ST_EMPTY;
				end else if (r.op == bid_pkg::OP_POP_FRONT) begin
					o.result_value = shadow_words[slot_at(0)];
					shrink(1'b1);
				end else begin
					o.result_value = shadow_words[slot_at(held - 1)];
					shrink(1'b0);
				end
			end
			bid_pkg::OP_INSERT: begin
				// range is checked before fullness
				if (pos > held) begin
					o.status = bid_pkg::ST_RANGE;
				end else if (held >= DEPTH) begin
					o.status = bid_pkg::ST_FULL;
				end else begin
					extend(1'b0);
					for (i = held - 1; i > pos; i--)
						shadow_words[slot_at(i)] = shadow_words[slot_at(i - 1)];
					shadow_words[slot_at(pos)] = r.data_value;
				end
			end
			bid_pkg::OP_REMOVE: begin
				if (pos >= held) begin
					o.status = bid_pkg::ST_RANGE;
				end else begin
					for (i = pos; i + 1 < held; i++)
						shadow_words[slot_at(i)] = shadow_words[slot_at(i + 1)];
					shrink(1'b0);
				end
			end
			bid_pkg::OP_READ: begin
				if (pos >= held)
					o.status = bid_pkg::ST_RANGE;
				else
					o.result_value = shadow_words[slot_at(pos)];
			end
			bid_pkg::OP_REVERSE: flipped = !flipped;
			bid_pkg::OP_CLEAR: begin
				held    = 0;
				head    = '0;
				flipped = 1'b0;
			end
			default: ;
		endcase
		o.entry_count = 5'(held);
		o.is_empty    = (held == 0);
		o.front_word  = (held != 0) ? shadow_words[slot_at(0)] : '0;
		o.back_word   = (held != 0) ? shadow_words[slot_at(held - 1)] : '0;
		return o;
	endfunction

	// mostly no gap, some short, a few long
	function automatic int unsigned idle_len();
		int unsigned roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bid_pkg::req_t random_req(mix_t mix);
		bid_pkg::req_t r;
		int unsigned   roll;
		int unsigned   grow_cut;
		case (mix)
			MIX_GROW:   grow_cut = 70;
			MIX_SHRINK: grow_cut = 20;
			default:    grow_cut = 45;
		endcase
		roll = $urandom_range(0, 99);
		if (roll < grow_cut) begin
			roll = $urandom_range(0, 2);
			r.op = (roll == 0) ? bid_pkg::OP_PUSH_FRONT :
				(roll == 1) ? bid_pkg::OP_PUSH_BACK : bid_pkg::OP_INSERT;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 55)
				r.op = (roll < 18) ? bid_pkg::OP_POP_FRONT :
					(roll < 36) ? bid_pkg::OP_POP_BACK : bid_pkg::OP_REMOVE;
			else if (roll < 85)
				r.op = bid_pkg::OP_READ;
			else if (roll < 94)
				r.op = bid_pkg::OP_REVERSE;
			else if (roll < 97)
				r.op = bid_pkg::OP_CLEAR;
			else
				r.op = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		end
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			roll = $urandom_range(0, 3);
			r.data_value = (roll == 0) ? WORD_MIN : (roll == 1) ? WORD_MAX :
				(roll == 2) ? WORD_ONES : '0;
		end else begin
			r.data_value = $urandom;
		end
		// keep most positions near the live range, the rest anywhere
		if ($urandom_range(0, 4) != 0)
			r.position = 5'($urandom_range(0, held));
		else
			r.position = 5'($urandom_range(0, POS_TOP));
		return r;
	endfunction

	function automatic step_t row(logic [3:0] op, logic [31:0] data, logic [4:0] pos,
			int reps = 1, bit pinned = 1'b0, bid_pkg::rsp_t want = '0);
		step_t s;
		s.rq.op         = op;
		s.rq.data_value = data;
		s.rq.position   = pos;
		s.reps          = reps;
		s.pinned        = pinned;
		s.want          = want;
		return s;
	endfunction

	// hand one item to the block and record what it must answer
	task automatic offer(input bid_pkg::req_t r, input bit pinned, input bid_pkg::rsp_t want);
		int unsigned   gap;
		bid_pkg::rsp_t predicted;
		gap = idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (!req_ready);
		predicted = deque_apply(r);
		pending_rsp.insert(pending_rsp.size(), pinned ? want : predicted);
		sent++;
	endtask

	task automatic flag_mismatch(input string what, input bid_pkg::rsp_t want,
			input bid_pkg::rsp_t got);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("[%0t] %s", $realtime, what);
			$display("  exp value %h status %0d count %0d empty %0d front %h back %h",
				want.result_value, want.status, want.entry_count, want.is_empty,
				want.front_word, want.back_word);
			$display("  got value %h status %0d count %0d empty %0d front %h back %h",
				got.result_value, got.status, got.entry_count, got.is_empty,
				got.front_word, got.back_word);
		end
	endtask

	always @(posedge clk) begin
		bid_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			taken++;
			status_seen[rsp.status]++;
			if (pending_rsp.size() == 0) begin
				flag_mismatch("response with nothing outstanding", '0, rsp);
			end else begin
				want = pending_rsp[0];
				pending_rsp.delete(0);
				if (rsp.result_value !== want.result_value || rsp.status !== want.status ||
					rsp.entry_count !== want.entry_count || rsp.is_empty !== want.is_empty ||
					rsp.front_word !== want.front_word || rsp.back_word !== want.back_word)
					flag_mismatch("response mismatch", want, rsp);
			end
		end
	end

	// output side: random stalls, plus a long hold when asked for
	initial begin : sink
		int unsigned stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_now) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_now = 1'b0;
				holds_done++;
			end
			stall = idle_len();
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	initial begin : stimulus
		step_t         plan [$];
		bid_pkg::req_t cur;
		mix_t          mix;
		int unsigned   directed_n;

		// after reset, out of range and extremes of data and position
		plan.insert(plan.size(), row(bid_pkg::OP_POP_FRONT, '0, '0, 1, 1'b1,
			'{'0, bid_pkg::ST_EMPTY, 5'd0, 1'b1, '0, '0}));
		plan.insert(plan.size(), row(bid_pkg::OP_POP_BACK, WORD_ONES, POS_TOP, 1, 1'b1,
			'{'0, bid_pkg::ST_EMPTY, 5'd0, 1'b1, '0, '0}));
		plan.insert(plan.size(), row(bid_pkg::OP_READ, '0, '0, 1, 1'b1,
			'{'0, bid_pkg::ST_RANGE, 5'd0, 1'b1, '0, '0}));
		plan.insert(plan.size(), row(bid_pkg::OP_REMOVE, '0, '0, 1, 1'b1,
			'{'0, bid_pkg::ST_RANGE, 5'd0, 1'b1, '0, '0}));
		plan.insert(plan.size(), row(bid_pkg::OP_INSERT, WORD_MIN, 5'd1, 1, 1'b1,
			'{'0, bid_pkg::ST_RANGE, 5'd0, 1'b1, '0, '0}));
		plan.insert(plan.size(), row(bid_pkg::OP_INSERT, WORD_MAX, '0, 1, 1'b1,
			'{'0, bid_pkg::ST_OK, 5'd1, 1'b0, WORD_MAX, WORD_MAX}));
		plan.insert(plan.size(), row(bid_pkg::OP_PUSH_FRONT, WORD_MIN, '0, 1, 1'b1,
			'{'0, bid_pkg::ST_OK, 5'd2, 1'b0, WORD_MIN, WORD_MAX}));
		plan.insert(plan.size(), row(bid_pkg::OP_PUSH_BACK, WORD_ONES, POS_TOP));
		plan.insert(plan.size(), row(bid_pkg::OP_REVERSE, '0, '0));
		plan.insert(plan.size(), row(bid_pkg::OP_READ, '0, '0));
		plan.insert(plan.size(), row(bid_pkg::OP_INSERT, '0, 5'd2));
		plan.insert(plan.size(), row(bid_pkg::OP_REMOVE, '0, 5'd1));
		plan.insert(plan.size(), row(OP_SPARE_FIRST, 32'h1234_5678, 5'd3));
		plan.insert(plan.size(), row(OP_SPARE_LAST, WORD_ONES, POS_TOP));
		plan.insert(plan.size(), row(bid_pkg::OP_READ, '0, POS_TOP));
		plan.insert(plan.size(), row(bid_pkg::OP_CLEAR, '0, '0, 1, 1'b1,
			'{'0, bid_pkg::ST_OK, 5'd0, 1'b1, '0, '0}));
		plan.insert(plan.size(), row(bid_pkg::OP_POP_BACK, '0, '0, 1, 1'b1,
			'{'0, bid_pkg::ST_EMPTY, 5'd0, 1'b1, '0, '0}));
		// fill to the top, then hit the full and out-of-range cases
		plan.insert(plan.size(), row(bid_pkg::OP_PUSH_BACK, 32'h1000, '0, DEPTH));
		plan.insert(plan.size(), row(bid_pkg::OP_PUSH_FRONT, 32'h55, '0, 1, 1'b1,
			'{'0, bid_pkg::ST_FULL, 5'd16, 1'b0, 32'h1000, 32'h100F}));
		plan.insert(plan.size(), row(bid_pkg::OP_INSERT, 32'h66, 5'd3, 1, 1'b1,
			'{'0, bid_pkg::ST_FULL, 5'd16, 1'b0, 32'h1000, 32'h100F}));
		plan.insert(plan.size(), row(bid_pkg::OP_INSERT, 32'h77, 5'd17, 1, 1'b1,
			'{'0, bid_pkg::ST_RANGE, 5'd16, 1'b0, 32'h1000, 32'h100F}));
		plan.insert(plan.size(), row(bid_pkg::OP_READ, '0, 5'd15));
		plan.insert(plan.size(), row(bid_pkg::OP_REVERSE, '0, '0));
		plan.insert(plan.size(), row(bid_pkg::OP_REMOVE, '0, 5'd15));
		plan.insert(plan.size(), row(bid_pkg::OP_POP_FRONT, '0, '0, DEPTH));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			for (int n = 0; n < plan[k].reps; n++) begin
				cur            = plan[k].rq;
				cur.data_value = plan[k].rq.data_value + n;
				offer(cur, plan[k].pinned, plan[k].want);
			end
		end
		directed_n = sent;

		for (int b = 0; b < BURSTS; b++) begin
			mix  = mix_t'(b % 3);
			calm = (b % 6 == 2);
			if (b == 4 || b == 11)
				hold_now = 1'b1;
			for (int j = 0; j < BURST_ITEMS; j++)
				offer(random_req(mix), 1'b0, '0);
		end
		calm      = 1'b0;
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run sent %0d requests (%0d from the directed table), checked %0d responses.",
			sent, directed_n, taken);
		$display("Statuses: ok %0d, empty %0d, full %0d, range %0d; %0d long output holds.",
			status_seen[bid_pkg::ST_OK], status_seen[bid_pkg::ST_EMPTY],
			status_seen[bid_pkg::ST_FULL], status_seen[bid_pkg::ST_RANGE], holds_done);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ bounded_indexed_deque_core.f @@
design/bid_pkg.sv
design/bid_datapath.sv
design/bid_ctrl.sv
design/bounded_indexed_deque_core.sv
verif/tb_top.sv
